[src/key_value_record_lookup_unit_defines.svh]
// Assertion macros for the key/value record lookup unit.
// Used by the top level only; no other dependencies.
`ifndef KEY_VALUE_RECORD_LOOKUP_UNIT_DEFINES_SVH
`define KEY_VALUE_RECORD_LOOKUP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define KVRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kvrl assertion failed");
// Next-cycle implication, disabled while reset is held.
`define KVRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kvrl assertion failed");
`else
`define KVRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define KVRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/kvrl_pkg.sv]
// Shared types and constants of the key/value record lookup unit.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package kvrl_pkg;

    localparam int unsigned KVRL_MAX_NAME_CHARS = 8;
    localparam int unsigned CHAR_W              = 8;
    localparam int unsigned NAME_CHARS_W        = 64;
    localparam int unsigned NAME_LEN_W          = 4;
    localparam int unsigned VALUE_LEN_W         = 12;
    localparam int unsigned CFG_IDX_W           = 2;
    localparam int unsigned CFG_DATA_W          = 64;

    localparam logic [CHAR_W-1:0]      SEPARATOR   = 8'h3D;
    localparam logic [CHAR_W-1:0]      NUL         = 8'h00;
    localparam logic [VALUE_LEN_W-1:0] MAX_LEN_RST = 12'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NAME_CHARS       = 2'd0,
        CFG_NAME_LENGTH      = 2'd1,
        CFG_MAX_VALUE_LENGTH = 2'd2
    } t_cfg_idx;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_START = 6'b000010,
        PH_NAME  = 6'b000100,
        PH_EQ    = 6'b001000,
        PH_VALUE = 6'b010000,
        PH_SKIP  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0]      value_byte;
        logic                   value_valid;
        logic                   done_res;
        logic                   found;
        logic [VALUE_LEN_W-1:0] value_length;
    } t_result;

endpackage

`default_nettype wire

[src/kvrl_intf.sv]
// Valid/ready channel interfaces: area bytes in, results out, register writes.
// Depends on kvrl_pkg for field widths.
`default_nettype none

interface kvrl_in_if import kvrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] area_byte;
    logic              first_byte;
    logic              last_byte;

    modport source (output valid, area_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, area_byte, first_byte, last_byte, output ready);
endinterface

interface kvrl_out_if import kvrl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CHAR_W-1:0]      value_byte;
    logic                   value_valid;
    logic                   done_res;
    logic                   found;
    logic [VALUE_LEN_W-1:0] value_length;

    modport source (output valid, value_byte, value_valid, done_res, found, value_length,
                    input ready);
    modport sink   (input valid, value_byte, value_valid, done_res, found, value_length,
                    output ready);
endinterface

interface kvrl_cfg_if import kvrl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/key_value_record_lookup_unit.sv]
// Key/value record lookup: scans a settings area one byte per word and
// streams the value of the record whose name matches the configured name.
// Depends on kvrl_pkg, the kvrl_*_if interfaces and the assertion macro header.
// Usage:
//   i_in   carries one area byte per word, with first_byte marking the start
//          of the area (starts a new search, abandons any running one) and
//          last_byte marking its end.
//   o_out  carries at most one result word per input word: a value byte
//          (value_valid) and/or the end of the search (done_res, found,
//          value_length). Words that cause no result are absorbed silently.
//   i_cfg  writes name_chars (0), name_length (1), max_value_length (2);
//          always ready. Write only while no search is in flight.
// Timing: one input word per cycle while the skid register is empty. A
//   result is registered in the output register, or in the skid register
//   while the output register is held. Per byte: compares and a 12-bit count update.
// Stall: an output register plus a one-word skid register sit on the
//   result side; i_in.ready drops only while the skid register is full.
// Reset: search state returns to finished (waits for a first byte), the
//   result registers empty, and the registers take their reset values
//   (name 0, length 1, value limit 255).
`default_nettype none
`include "key_value_record_lookup_unit_defines.svh"

module key_value_record_lookup_unit import kvrl_pkg::*; #(
    parameter int unsigned MAX_NAME_CHARS = KVRL_MAX_NAME_CHARS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    kvrl_in_if.sink           i_in,
    kvrl_out_if.source        o_out,
    kvrl_cfg_if.sink          i_cfg
);

    localparam int unsigned IDX_W      = $clog2(MAX_NAME_CHARS + 1);
    localparam int unsigned CHAR_SEL_W = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;
    localparam int unsigned NAME_W     = CHAR_W * MAX_NAME_CHARS;

    // configuration registers, kept in effective form
    logic [NAME_W-1:0]      r_name_chars;
    logic [IDX_W-1:0]       r_name_len;
    logic [VALUE_LEN_W-1:0] r_max_len;

    // search state
    t_phase                 r_phase,     n_phase;
    logic [IDX_W-1:0]       r_match_idx, n_match_idx;
    logic [VALUE_LEN_W-1:0] r_value_cnt, n_value_cnt;

    // result side: output register and skid register
    t_result                r_out,  r_skid;
    logic                   r_out_valid, r_skid_valid;

    t_result                res;
    logic                   res_push;
    logic                   in_acc;
    logic                   out_take;

    // effective-value conversion of register writes
    logic [NAME_LEN_W-1:0]  wr_len;
    logic [IDX_W-1:0]       wr_len_eff;
    logic [VALUE_LEN_W-1:0] wr_max;

    // step datapath
    t_phase                 cur_phase;
    logic [IDX_W-1:0]       cur_idx;
    logic [VALUE_LEN_W-1:0] cur_cnt;
    logic [IDX_W-1:0]       m_idx;
    logic [IDX_W-1:0]       m_idx_inc;
    logic [CHAR_SEL_W-1:0]  m_sel;
    logic [CHAR_W-1:0]      m_char;
    logic [VALUE_LEN_W-1:0] cnt_inc;
    logic                   is_nul;
    logic                   active;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_take    = r_out_valid && o_out.ready;

    // ------------------------------------------------------------------
    // Configuration: clamp length to 1..MAX_NAME_CHARS, value limit to >= 1
    // ------------------------------------------------------------------
    always_comb begin
        wr_len = i_cfg.data[NAME_LEN_W-1:0];
        if (wr_len == '0) begin
            wr_len_eff = IDX_W'(1);
        end else if (32'(wr_len) > MAX_NAME_CHARS) begin
            wr_len_eff = IDX_W'(MAX_NAME_CHARS);
        end else begin
            wr_len_eff = IDX_W'(wr_len);
        end
        wr_max = i_cfg.data[VALUE_LEN_W-1:0];
        if (wr_max == '0) begin
            wr_max = VALUE_LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_chars <= '0;
            r_name_len   <= IDX_W'(1);
            r_max_len    <= MAX_LEN_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_NAME_CHARS:       r_name_chars <= i_cfg.data[NAME_W-1:0];
                CFG_NAME_LENGTH:      r_name_len   <= wr_len_eff;
                CFG_MAX_VALUE_LENGTH: r_max_len    <= wr_max;
                default: ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One byte step: a first byte forces a fresh search at a record start
    // ------------------------------------------------------------------
    always_comb begin
        cur_phase = i_in.first_byte ? PH_START : r_phase;
        cur_idx   = i_in.first_byte ? '0 : r_match_idx;
        cur_cnt   = i_in.first_byte ? '0 : r_value_cnt;
        is_nul    = (i_in.area_byte == NUL);
        active    = (cur_phase != PH_IDLE);

        // name compare: a record start always compares the first character
        m_idx     = (cur_phase == PH_START) ? '0 : cur_idx;
        m_idx_inc = m_idx + IDX_W'(1);
        m_sel     = CHAR_SEL_W'(m_idx);
        m_char    = r_name_chars[m_sel*CHAR_W +: CHAR_W];
        cnt_inc   = cur_cnt + VALUE_LEN_W'(1);

        n_phase     = cur_phase;
        n_match_idx = cur_idx;
        n_value_cnt = cur_cnt;
        res         = '0;

        case (cur_phase)
            PH_IDLE: ; // hold: ignore bytes until the next first byte
            PH_START, PH_NAME: begin
                if ((cur_phase == PH_START) && is_nul) begin
                    res.done_res = 1'b1;
                end else begin
                    n_match_idx = m_idx;
                    if (is_nul) begin
                        n_phase = PH_START;
                    end else if (i_in.area_byte == m_char) begin
                        n_match_idx = m_idx_inc;
                        n_phase     = (m_idx_inc >= r_name_len) ? PH_EQ : PH_NAME;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_EQ: begin
                if (i_in.area_byte == SEPARATOR) begin
                    n_phase     = PH_VALUE;
                    n_value_cnt = '0;
                end else if (is_nul) begin
                    n_phase = PH_START;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_VALUE: begin
                if (is_nul) begin
                    res.done_res     = 1'b1;
                    res.found        = 1'b1;
                    res.value_length = cur_cnt;
                end else begin
                    res.value_byte  = i_in.area_byte;
                    res.value_valid = 1'b1;
                    n_value_cnt     = cnt_inc;
                    if (cnt_inc >= r_max_len) begin
                        res.done_res     = 1'b1;
                        res.found        = 1'b1;
                        res.value_length = cnt_inc;
                    end
                end
            end
            default: begin
                // skip the rest of a mismatching record
                n_phase = is_nul ? PH_START : PH_SKIP;
            end
        endcase

        // end of area without a verdict: not found, keep any value byte
        if (active && !res.done_res && i_in.last_byte) begin
            res.done_res     = 1'b1;
            res.found        = 1'b0;
            res.value_length = '0;
        end
        if (res.done_res) begin
            n_phase     = PH_IDLE;
            n_match_idx = '0;
        end
        res_push = in_acc && (res.value_valid || res.done_res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_match_idx <= '0;
            r_value_cnt <= '0;
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_match_idx <= n_match_idx;
            r_value_cnt <= n_value_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Result side: advance skid into the output register when it drains
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_push;
            end
        end else if (res_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_push) begin
            r_skid <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.value_byte   = r_out.value_byte;
    assign o_out.value_valid  = r_out.value_valid;
    assign o_out.done_res     = r_out.done_res;
    assign o_out.found        = r_out.found;
    assign o_out.value_length = r_out.value_length;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KVRL_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `KVRL_ASSERT_NOW(a_found_needs_done, i_clk, i_rst_n, r_out_valid && r_out.found, r_out.done_res)
    `KVRL_ASSERT_NOW(a_len_found, i_clk, i_rst_n, r_out_valid && !r_out.found, r_out.value_length == '0)
    `KVRL_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, res_push && res.done_res, r_phase == PH_IDLE)

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for key_value_record_lookup_unit: a directed table, random settings areas
// under random valid/ready idling and a long value, checked against typed words or a built-in predictor.
// Depends on kvrl_pkg, the kvrl_*_if channel interfaces and the block itself.

module tb_top import kvrl_pkg::*; ();

    localparam int unsigned DIRECTED_ROWS = 25;
    localparam int unsigned RANDOM_WORDS  = 1050;
    localparam int unsigned MAX_WAIT      = 11;
    localparam int unsigned QUIET_WORDS   = 30;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_VALUE    = 300;
    localparam int unsigned MAX_REPORTS   = 100;

    // One area byte as it travels on the input channel.
    typedef struct packed {
        logic [CHAR_W-1:0] area_byte;
        logic              first_byte;
        logic              last_byte;
    } t_area_word;

    // How a row of the directed table is checked.
    typedef enum logic [1:0] {
        CHK_NONE    = 2'd0,  // no result word may come
        CHK_WORD    = 2'd1,  // the typed word must come
        CHK_PREDICT = 2'd2   // whatever the predictor says
    } t_check;

    typedef struct packed {
        t_area_word word;
        t_check     check;
        t_result    result;
    } t_table_row;

    localparam logic [1:0]  F_NONE  = 2'b00;
    localparam logic [1:0]  F_FIRST = 2'b10;
    localparam logic [1:0]  F_LAST  = 2'b01;
    localparam t_result     NO_WORD = '0;
    localparam logic [63:0] NAME_AB = 64'h6261;  // "ab", first character in the low byte

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kvrl_in_if  in_ch ();
    kvrl_out_if out_ch ();
    kvrl_cfg_if cfg_ch ();

    key_value_record_lookup_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and the search state.
    // ------------------------------------------------------------------
    logic [NAME_CHARS_W-1:0] srch_name  = '0;
    logic [NAME_LEN_W-1:0]   srch_len   = 4'd1;
    logic [VALUE_LEN_W-1:0]  srch_limit = MAX_LEN_RST;
    t_phase                  scan_ph    = PH_IDLE;
    logic [NAME_LEN_W-1:0]   name_pos   = '0;
    logic [VALUE_LEN_W-1:0]  copied     = '0;

    t_result    awaited_results [$];
    t_area_word area_q [$];

    int unsigned fail_count     = 0;
    int unsigned words_scanned  = 0;
    int unsigned value_bytes    = 0;
    int unsigned searches_ended = 0;
    int unsigned searches_found = 0;
    int unsigned tx_quiet       = 0;
    int unsigned rx_quiet       = 0;
    bit          rx_hold_req    = 1'b0;
    bit          rx_holding     = 1'b0;

    // Name length as the block uses it: zero counts as one, saturate at the maximum.
    function automatic logic [NAME_LEN_W-1:0] name_span();
        if (srch_len == '0) return 4'd1;
        if (srch_len > KVRL_MAX_NAME_CHARS) return 4'(KVRL_MAX_NAME_CHARS);
        return srch_len;
    endfunction

    // Compare one name character; a nul always closes the record.
    function automatic void match_name_char(input logic [CHAR_W-1:0] b);
        if (b == NUL) begin
            scan_ph = PH_START;
        end else if (b == srch_name[8*name_pos[2:0] +: 8]) begin
            name_pos = name_pos + 4'd1;
            scan_ph  = (name_pos >= name_span()) ? PH_EQ : PH_NAME;
        end else begin
            scan_ph = PH_SKIP;
        end
    endfunction

    // Advance the search by one accepted area byte; return 1 when it causes a result word.
    function automatic bit scan_area_byte(input t_area_word w, output t_result r);
        logic [VALUE_LEN_W-1:0] lim;
        bit                     ends;
        r    = NO_WORD;
        ends = 1'b0;
        lim  = (srch_limit == '0) ? 12'd1 : srch_limit;
        if (w.first_byte) begin
            scan_ph  = PH_START;
            name_pos = '0;
            copied   = '0;
        end
        if (scan_ph == PH_IDLE) return 1'b0;
        case (scan_ph)
            PH_START: begin
                if (w.area_byte == NUL) begin
                    ends = 1'b1;
                end else begin
                    name_pos = '0;
                    match_name_char(w.area_byte);
                end
            end
            PH_NAME: match_name_char(w.area_byte);
            PH_EQ: begin
                if (w.area_byte == SEPARATOR) begin
                    scan_ph = PH_VALUE;
                    copied  = '0;
                end else begin
                    scan_ph = (w.area_byte == NUL) ? PH_START : PH_SKIP;
                end
            end
            PH_VALUE: begin
                if (w.area_byte == NUL) begin
                    ends           = 1'b1;
                    r.found        = 1'b1;
                    r.value_length = copied;
                end else begin
                    r.value_byte  = w.area_byte;
                    r.value_valid = 1'b1;
                    copied        = copied + 12'd1;
                    if (copied >= lim) begin
                        ends           = 1'b1;
                        r.found        = 1'b1;
                        r.value_length = copied;
                    end
                end
            end
            default: scan_ph = (w.area_byte == NUL) ? PH_START : PH_SKIP;
        endcase
        // The last byte of the area closes a search still running as not found.
        if (!ends && w.last_byte) begin
            ends           = 1'b1;
            r.found        = 1'b0;
            r.value_length = '0;
        end
        if (ends) begin
            scan_ph  = PH_IDLE;
            name_pos = '0;
        end
        r.done_res = ends;
        return r.value_valid || ends;
    endfunction

    // Cycles to idle before the next word: mostly random, now and then a quiet stretch.
    function automatic int unsigned draw_wait(ref int unsigned quiet_left);
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            quiet_left = QUIET_WORDS;
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Results are typed in where they are obvious.
    // ------------------------------------------------------------------
    t_table_row directed_rows [DIRECTED_ROWS] = '{
        {8'h41, F_NONE,  CHK_NONE,    NO_WORD},                            // idle: ignore
        {NUL,   F_FIRST, CHK_WORD,    {8'h00, 1'b0, 1'b1, 1'b0, 12'd0}},   // empty area
        {8'h61, F_FIRST, CHK_PREDICT, NO_WORD},
        {8'h62, F_NONE,  CHK_PREDICT, NO_WORD},
        {8'h78, F_NONE,  CHK_PREDICT, NO_WORD},                            // no '=' after name
        {8'h79, F_NONE,  CHK_PREDICT, NO_WORD},
        {NUL,   F_NONE,  CHK_PREDICT, NO_WORD},
        {8'h78, F_NONE,  CHK_PREDICT, NO_WORD},                            // name not at start
        {8'h61, F_NONE,  CHK_PREDICT, NO_WORD},
        {8'h62, F_NONE,  CHK_PREDICT, NO_WORD},
        {SEPARATOR, F_NONE, CHK_PREDICT, NO_WORD},
        {NUL,   F_NONE,  CHK_PREDICT, NO_WORD},
        {8'h61, F_NONE,  CHK_PREDICT, NO_WORD},
        {NUL,   F_NONE,  CHK_PREDICT, NO_WORD},                            // nul inside name
        {8'h61, F_NONE,  CHK_PREDICT, NO_WORD},
        {8'h62, F_NONE,  CHK_PREDICT, NO_WORD},
        {SEPARATOR, F_NONE, CHK_PREDICT, NO_WORD},
        {8'hFF, F_NONE,  CHK_WORD,    {8'hFF, 1'b1, 1'b0, 1'b0, 12'd0}},
        {8'h61, F_FIRST, CHK_PREDICT, NO_WORD},                            // restart mid-value
        {8'h62, F_NONE,  CHK_PREDICT, NO_WORD},
        {SEPARATOR, F_NONE, CHK_PREDICT, NO_WORD},
        {8'h80, F_NONE,  CHK_WORD,    {8'h80, 1'b1, 1'b0, 1'b0, 12'd0}},
        {8'h01, F_NONE,  CHK_WORD,    {8'h01, 1'b1, 1'b0, 1'b0, 12'd0}},
        {8'h7F, F_LAST,  CHK_WORD,    {8'h7F, 1'b1, 1'b1, 1'b1, 12'd3}},   // limit of 3 hit
        {8'h51, F_LAST,  CHK_NONE,    NO_WORD}                             // idle: ignore
    };

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.area_byte  <= '0;
        in_ch.first_byte <= 1'b0;
        in_ch.last_byte  <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_NAME_CHARS;
        cfg_ch.data      <= '0;
    end

    // Offer one word after a random gap, hold it until accepted, then predict.
    task automatic send_word(input t_area_word w, output bit has, output t_result r);
        int unsigned gap;
        gap = draw_wait(tx_quiet);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.area_byte  <= w.area_byte;
        in_ch.first_byte <= w.first_byte;
        in_ch.last_byte  <= w.last_byte;
        do @(posedge i_clk); while (!in_ch.ready);
        if (w.first_byte || scan_ph != PH_IDLE) words_scanned++;
        has = scan_area_byte(w, r);
    endtask

    task automatic play_area();
        t_result r;
        bit      has;
        foreach (area_q[i]) begin
            send_word(area_q[i], has, r);
            if (has) awaited_results.push_back(r);
        end
    endtask

    // Drop valid, wait for every awaited word, then let the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_NAME_CHARS:       srch_name  = data;
            CFG_NAME_LENGTH:      srch_len   = data[NAME_LEN_W-1:0];
            CFG_MAX_VALUE_LENGTH: srch_limit = data[VALUE_LEN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_search(input logic [63:0] nm, input logic [3:0] len,
                              input logic [11:0] lim);
        write_reg(CFG_NAME_CHARS, nm);
        write_reg(CFG_NAME_LENGTH, 64'(len));
        write_reg(CFG_MAX_VALUE_LENGTH, 64'(lim));
    endtask

    function automatic void push_byte(input logic [CHAR_W-1:0] b);
        area_q.push_back({b, F_NONE});
    endfunction

    // Build one area: mostly well-formed records with random content, some broken ones,
    // or pure noise with random first/last marks.
    function automatic void build_area(input int unsigned records, input int unsigned cap,
                                       input bit noise);
        int unsigned kind;
        int unsigned keep;
        logic [7:0]  c;
        area_q.delete();
        if (noise) begin
            repeat ($urandom_range(4, 24))
                area_q.push_back({8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                  $urandom_range(0, 7) == 0});
            return;
        end
        repeat (records) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
                continue;
            end
            keep = (kind == 6) ? $urandom_range(0, name_span() - 1) : name_span();
            for (int i = 0; i < keep; i++) begin
                c = srch_name[8*i +: 8];
                if (kind == 7 && i == keep - 1) c = c ^ 8'($urandom_range(1, 255));
                push_byte(c);
            end
            if (kind == 8) push_byte(8'($urandom_range(1, 255)));  // name one too long
            push_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : SEPARATOR);
            repeat ($urandom_range(0, cap)) push_byte(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 15) != 0) push_byte(NUL);
        end
        if (area_q.size() == 0) push_byte(NUL);
        area_q[0].first_byte = 1'b1;
        area_q[area_q.size()-1].last_byte = 1'b1;
        if ($urandom_range(0, 7) == 0) area_q[$urandom_range(0, area_q.size()-1)].first_byte = 1'b1;
        if ($urandom_range(0, 7) == 0) area_q[$urandom_range(0, area_q.size()-1)].last_byte = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, one long hold-off on request.
    // ------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result word with none awaited, expected nothing, actual %0h",
                         $time, {out_ch.value_byte, out_ch.value_valid, out_ch.done_res,
                                 out_ch.found, out_ch.value_length});
            return;
        end
        want = awaited_results.pop_front();
        compare_field("value_byte",   12'(want.value_byte), 12'(out_ch.value_byte));
        compare_field("value_valid",  12'(want.value_valid), 12'(out_ch.value_valid));
        compare_field("done_res",     12'(want.done_res), 12'(out_ch.done_res));
        compare_field("found",        12'(want.found), 12'(out_ch.found));
        compare_field("value_length", want.value_length, out_ch.value_length);
        if (want.value_valid) value_bytes++;
        if (want.done_res) searches_ended++;
        if (want.done_res && want.found) searches_found++;
    endtask

    initial begin : result_sink
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            if (rx_hold_req) begin
                // Hold off long enough for the block to fill and stall its input.
                rx_holding = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                rx_holding  = 1'b0;
            end else begin
                stall = draw_wait(rx_quiet);
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid && !rx_hold_req);
            if (out_ch.valid) check_result();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_result     r;
        bit          has;
        int unsigned setting;
        int unsigned cap;
        logic [63:0] nm;
        logic [3:0]  len;
        logic [11:0] lim;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: search "ab", copy at most three value bytes.
        set_search(NAME_AB, 4'd2, 12'd3);
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, has, r);
            case (directed_rows[i].check)
                CHK_WORD:    awaited_results.push_back(directed_rows[i].result);
                CHK_PREDICT: if (has) awaited_results.push_back(r);
                default: ;
            endcase
        end
        drain();

        // Random part: walk the extreme settings first, then random ones.
        setting = 0;
        while (words_scanned < DIRECTED_ROWS + RANDOM_WORDS) begin
            for (int k = 0; k < 8; k++) nm[8*k +: 8] = 8'($urandom_range(1, 255));
            case (setting)
                0: begin nm = '1; len = 4'd8; lim = 12'd1; end
                1: begin nm = 64'h0101_0101_0101_0101; len = 4'd15; lim = 12'd0; end
                2: begin nm = '0; len = 4'd1; lim = 12'd2; end
                3: begin len = 4'd0; lim = 12'd4095; end
                default: begin
                    if ($urandom_range(0, 7) == 0) nm = {$urandom, $urandom};
                    len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(1, 8));
                    case ($urandom_range(0, 3))
                        0: lim = 12'($urandom_range(0, 2));
                        1: lim = 12'($urandom_range(3, 12));
                        2: lim = 12'($urandom_range(13, 40));
                        default: lim = 12'($urandom_range(41, 4095));
                    endcase
                end
            endcase
            set_search(nm, len, lim);
            cap = (lim > 38) ? 40 : lim + 2;
            repeat ($urandom_range(3, 6)) begin
                build_area($urandom_range(1, 6), cap, $urandom_range(0, 7) == 0);
                play_area();
                // Now and then pause the sender until the results have all come back.
                if ($urandom_range(0, 3) == 0) drain();
            end
            drain();
            setting++;
        end

        // A long value under the largest limit, with the receiver held off at the start.
        set_search({56'h0, 8'($urandom_range(1, 255))}, 4'd1, 12'd4095);
        area_q.delete();
        push_byte(srch_name[7:0]);
        push_byte(SEPARATOR);
        repeat (LONG_VALUE) push_byte(8'($urandom_range(1, 255)));
        push_byte(NUL);
        area_q[0].first_byte = 1'b1;
        area_q[area_q.size()-1].last_byte = 1'b1;
        rx_hold_req = 1'b1;
        wait (rx_holding);
        play_area();
        drain();

        $display("tb_top: %0d area bytes scanned over %0d settings, %0d value bytes checked",
                 words_scanned, setting + 2, value_bytes);
        $display("tb_top: %0d searches ended, %0d with the name found",
                 searches_ended, searches_found);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
